>>> rtl/arfp_pkg.sv
`timescale 1ns / 1ps

package arfp_pkg;

    localparam int DEF_READINGS_PER_FRAME = 4;
    localparam int OUT_READINGS           = 4;
    localparam logic [15:0] CONVERTER_LIMIT = 16'd1023;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] reading_t;

    typedef enum logic
    {
        ACT_BYTE    = 1'b0,
        ACT_RESTART = 1'b1
    } action_t;

    typedef struct packed
    {
        action_t action;
        byte_t   rx_byte;
    } arfp_item_t;

    typedef struct packed
    {
        reading_t reading_a;
        reading_t reading_b;
        reading_t reading_c;
        reading_t reading_d;
        logic     frame_valid;
    } arfp_result_t;

endpackage

>>> rtl/addressed_reply_frame_parser.sv
`timescale 1ns / 1ps

// Reply frame parser for a received serial byte stream.
// Item channel (item_valid / item_stall / item): one item per byte, either a
// received byte or a restart that drops a partial frame.
// Result channel (reading_valid / reading_stall / readings): one item per
// complete frame, carrying four 16-bit readings and frame_valid.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes device_address;
// cfg_ready is always high. Write it only while the block is idle.
// An item taken lands in the input register; its result, if any, is loaded
// from there into the result register once the result side can take it.
// Throughput: one item per cycle while item_stall is low, set by the single
// pass of compare and assembly logic between the input and result registers.
// Reset clears the address, the hunt state and both valid flags; no
// clearing pass is needed.
// When the receiver stalls, the result register holds; byte items that do
// not complete a frame keep flowing, and item_stall rises only when the
// input register holds a frame-completing byte and the result is still full.

module addressed_reply_frame_parser
    import arfp_pkg::*;
#(
    parameter int READINGS_PER_FRAME = DEF_READINGS_PER_FRAME
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  arfp_item_t   item,
    output logic         reading_valid,
    input  logic         reading_stall,
    output arfp_result_t readings,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);

    logic         s1_valid_reg;
    logic         s1_valid_next;
    arfp_item_t   s1_item_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    arfp_result_t out_data_reg;
    logic [15:0]  device_address_reg;
    logic         fire;
    logic         emit;
    logic         accept;
    arfp_result_t result;

    arfp_core #(
        .READINGS_PER_FRAME (READINGS_PER_FRAME)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .item           (s1_item_reg),
        .device_address (device_address_reg),
        .emit           (emit),
        .result         (result)
    );

    assign cfg_ready     = 1'b1;
    assign fire          = s1_valid_reg && (!emit || !out_valid_reg || !reading_stall);
    assign item_stall    = s1_valid_reg && !fire;
    assign accept        = item_valid && !item_stall;
    assign s1_valid_next = accept || (s1_valid_reg && !fire);
    assign out_valid_next = (fire && emit) || (out_valid_reg && reading_stall);
    assign reading_valid = out_valid_reg;
    assign readings      = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            device_address_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                device_address_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
        if (fire && emit)
        begin
            out_data_reg <= result;
        end
    end

endmodule

>>> rtl/arfp_core.sv
`timescale 1ns / 1ps

module arfp_core
    import arfp_pkg::*;
#(
    parameter int READINGS_PER_FRAME = DEF_READINGS_PER_FRAME
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  arfp_item_t   item,
    input  logic [15:0]  device_address,
    output logic         emit,
    output arfp_result_t result
);

    localparam int PAYLOAD_BYTES = 2 * READINGS_PER_FRAME;
    localparam int CW            = $clog2(PAYLOAD_BYTES);
    localparam logic [CW-1:0] LAST_INDEX = CW'(PAYLOAD_BYTES - 1);

    byte_t         previous_byte_reg;
    byte_t         previous_byte_next;
    logic          collecting_reg;
    logic          collecting_next;
    logic [CW-1:0] payload_count_reg;
    logic [CW-1:0] payload_count_next;
    byte_t         payload_store_reg [PAYLOAD_BYTES];

    byte_t         view [PAYLOAD_BYTES];
    reading_t      rd [OUT_READINGS];
    logic [READINGS_PER_FRAME-1:0] in_limit;
    logic          is_byte;
    logic          last;

    assign is_byte = (item.action == ACT_BYTE);
    assign last    = (payload_count_reg == LAST_INDEX);
    assign emit    = is_byte && collecting_reg && last;

    always_comb
    begin
        previous_byte_next = previous_byte_reg;
        collecting_next    = collecting_reg;
        payload_count_next = payload_count_reg;
        if (fire)
        begin
            if (!is_byte)
            begin
                previous_byte_next = '0;
                collecting_next    = 1'b0;
                payload_count_next = '0;
            end
            else if (!collecting_reg)
            begin
                if ({previous_byte_reg, item.rx_byte} == device_address)
                begin
                    collecting_next    = 1'b1;
                    payload_count_next = '0;
                end
                else
                begin
                    previous_byte_next = item.rx_byte;
                end
            end
            else if (last)
            begin
                previous_byte_next = '0;
                collecting_next    = 1'b0;
                payload_count_next = '0;
            end
            else
            begin
                payload_count_next = payload_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_byte_reg <= '0;
            collecting_reg    <= 1'b0;
            payload_count_reg <= '0;
        end
        else
        begin
            previous_byte_reg <= previous_byte_next;
            collecting_reg    <= collecting_next;
            payload_count_reg <= payload_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && is_byte && collecting_reg)
        begin
            payload_store_reg[payload_count_reg] <= item.rx_byte;
        end
    end

    // last payload byte comes straight from the item
    always_comb
    begin
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            view[i] = payload_store_reg[i];
        end
        view[PAYLOAD_BYTES-1] = item.rx_byte;
    end

    for (genvar k = 0; k < READINGS_PER_FRAME; k++)
    begin : g_limit
        assign in_limit[k] = ({view[2*k], view[2*k+1]} <= CONVERTER_LIMIT);
    end

    for (genvar k = 0; k < OUT_READINGS; k++)
    begin : g_read
        if (k < READINGS_PER_FRAME)
        begin : g_used
            assign rd[k] = {view[2*k], view[2*k+1]};
        end
        else
        begin : g_zero
            assign rd[k] = '0;
        end
    end

    assign result.reading_a   = rd[0];
    assign result.reading_b   = rd[1];
    assign result.reading_c   = rd[2];
    assign result.reading_d   = rd[3];
    assign result.frame_valid = &in_limit;

endmodule

>>> rtl/arfp_checker.sv
`timescale 1ns / 1ps

module arfp_checker
    import arfp_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         item_stall,
    input logic         reading_valid,
    input logic         reading_stall,
    input arfp_result_t readings,
    input logic         cfg_valid,
    input logic         cfg_ready
);

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !reading_valid)
        else $error("result valid during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        reading_valid && reading_stall |=> reading_valid && $stable(readings))
        else $error("stalled result changed");

    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        reading_valid && readings.frame_valid |->
            readings.reading_a <= CONVERTER_LIMIT && readings.reading_b <= CONVERTER_LIMIT &&
            readings.reading_c <= CONVERTER_LIMIT && readings.reading_d <= CONVERTER_LIMIT)
        else $error("frame_valid set with reading over limit");

    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> reading_valid && reading_stall)
        else $error("item stalled with result side free");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind addressed_reply_frame_parser arfp_checker u_arfp_checker (.*);
